// File: sv/rdmc_pkg.sv
// Shared types and constants for the random DFS maze carver.
// No dependencies; used by random_dfs_maze_carver, its checker and its testbench.
`default_nettype none

package rdmc_pkg;

   // Grid geometry is fixed by the 4-bit row/column fields
   localparam int MAX_SIDE  = 16;
   localparam int COORD_W   = 4;
   localparam int CELL_W    = 2 * COORD_W;
   localparam int MAP_CELLS = MAX_SIDE * MAX_SIDE;
   localparam int SIDE_W    = 5;
   localparam int VCOUNT_W  = 9;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd15;
   localparam logic [SIDE_W-1:0] SIDE_MIN   = 5'd2;
   localparam logic [SIDE_W-1:0] SIDE_MAX   = 5'(MAX_SIDE);

   // Opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Directions
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef struct packed {
      logic               carved;
      logic [COORD_W-1:0] from_row;
      logic [COORD_W-1:0] from_col;
      logic [1:0]         wall_dir;
      logic               backtracked;
      logic               done_res;
   } result_type;

endpackage

`default_nettype wire

// File: sv/random_dfs_maze_carver.sv
// Randomized depth-first maze carver, one request beat per cycle unless stalled.
// Depends on rdmc_pkg (types, opcodes, direction codes, grid constants).
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  req     | in  | req_valid/req_ready  | op, start_row, start_col, random_dir
//  rsp     | out | rsp_valid/rsp_ready  | carved, from_row, from_col, wall_dir,
//          |     |                      | backtracked, done_res
//  csr     | in  | csr_wr_en            | csr_wr_data = cells_per_side
//
// Results: each response is written into the response queue when its
//   request is taken. The visited map lives in flops and the stack entry
//   below the top is prefetched from the stack RAM each cycle, so a pop
//   never waits on a RAM read.
// Reset: synchronous, clears the visited map, counters and walker; the
//   walker comes up finished. Stack RAM contents are not reset.
// Stalls: a two-entry response queue sits at the output; req_ready drops
//   only while both entries are held by a stalled consumer.
`default_nettype none

module random_dfs_maze_carver #(
   parameter int STACK_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [3:0]  req_start_row,
   input  wire logic [3:0]  req_start_col,
   input  wire logic [1:0]  req_random_dir,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_carved,
   output logic [3:0]       rsp_from_row,
   output logic [3:0]       rsp_from_col,
   output logic [1:0]       rsp_wall_dir,
   output logic             rsp_backtracked,
   output logic             rsp_done_res,

   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data
);

   localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNTW = $clog2(STACK_DEPTH + 1);
   localparam int CW   = rdmc_pkg::COORD_W;
   localparam int EW   = rdmc_pkg::CELL_W;
   localparam int MC   = rdmc_pkg::MAP_CELLS;
   localparam int SW   = rdmc_pkg::SIDE_W;
   localparam int VW   = rdmc_pkg::VCOUNT_W;

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   logic [SW-1:0]   side_cfg_ff;
   logic [MC-1:0]   visited_ff, visited_in;
   logic [CNTW-1:0] stack_cnt_ff, stack_cnt_in;
   logic [CW-1:0]   cur_row_ff, cur_row_in;
   logic [CW-1:0]   cur_col_ff, cur_col_in;
   logic [1:0]      pref_ff, pref_in;
   logic [VW-1:0]   vcount_ff, vcount_in;
   logic            finished_ff, finished_in;

   // Stack RAM and prefetch of the entry just below the top
   logic [EW-1:0]   stack_mem [STACK_DEPTH];
   logic [EW-1:0]   below_top_ff;
   logic            push_en;
   logic [AW-1:0]   push_addr;
   logic [EW-1:0]   push_data;
   logic [AW-1:0]   rd_addr;

   // Response queue
   rdmc_pkg::result_type res_q_ff [2];
   logic            wr_ptr_ff, rd_ptr_ff;
   logic [1:0]      q_cnt_ff;

   // Datapath
   logic            req_fire, rsp_fire;
   logic [SW-1:0]   side;
   logic [CW-1:0]   side_m1;
   logic [VW-1:0]   side_sq;
   logic [CW-1:0]   st_row, st_col;
   logic [3:0]      nb_inb;
   logic [3:0]      nb_open;
   logic [EW-1:0]   nb_idx [4];
   logic            found;
   logic [1:0]      sel_dir;
   logic [1:0]      scan_dir;
   logic [CNTW-1:0] cnt_dec;
   rdmc_pkg::result_type res;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign req_ready = (q_cnt_ff != 2'd2);

   // Effective side, saturated to 2..MAX_SIDE
   always_comb begin
      if (side_cfg_ff < rdmc_pkg::SIDE_MIN) begin
         side = rdmc_pkg::SIDE_MIN;
      end else if (side_cfg_ff > rdmc_pkg::SIDE_MAX) begin
         side = rdmc_pkg::SIDE_MAX;
      end else begin
         side = side_cfg_ff;
      end
   end

   assign side_m1 = CW'(side - SW'(1));
   assign side_sq = VW'(side) * VW'(side);

   // Start cell clamped into the grid
   assign st_row = ({1'b0, req_start_row} > {1'b0, side_m1}) ? side_m1 : req_start_row;
   assign st_col = ({1'b0, req_start_col} > {1'b0, side_m1}) ? side_m1 : req_start_col;

   // Neighbour cells in up/down/left/right order
   always_comb begin
      nb_idx[rdmc_pkg::DIR_UP]    = {CW'(cur_row_ff - CW'(1)), cur_col_ff};
      nb_idx[rdmc_pkg::DIR_DOWN]  = {CW'(cur_row_ff + CW'(1)), cur_col_ff};
      nb_idx[rdmc_pkg::DIR_LEFT]  = {cur_row_ff, CW'(cur_col_ff - CW'(1))};
      nb_idx[rdmc_pkg::DIR_RIGHT] = {cur_row_ff, CW'(cur_col_ff + CW'(1))};
      nb_inb[rdmc_pkg::DIR_UP]    = (cur_row_ff != '0);
      nb_inb[rdmc_pkg::DIR_DOWN]  = (SW'(cur_row_ff) + SW'(1)) < side;
      nb_inb[rdmc_pkg::DIR_LEFT]  = (cur_col_ff != '0);
      nb_inb[rdmc_pkg::DIR_RIGHT] = (SW'(cur_col_ff) + SW'(1)) < side;
      for (int d = 0; d < 4; d++) begin
         nb_open[d] = nb_inb[d] && !visited_ff[nb_idx[d]];
      end
   end

   // Rotating priority scan starting at the preferred direction
   always_comb begin
      found    = 1'b0;
      sel_dir  = rdmc_pkg::DIR_UP;
      scan_dir = rdmc_pkg::DIR_UP;
      for (int k = 0; k < 4; k++) begin
         scan_dir = 2'(pref_ff + 2'(k));
         if (!found && nb_open[scan_dir]) begin
            found   = 1'b1;
            sel_dir = scan_dir;
         end
      end
   end

   assign cnt_dec = CNTW'(stack_cnt_ff - CNTW'(1));

   // Next state and result for the accepted beat
   always_comb begin
      visited_in   = visited_ff;
      stack_cnt_in = stack_cnt_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      pref_in      = pref_ff;
      vcount_in    = vcount_ff;
      finished_in  = finished_ff;
      push_en      = 1'b0;
      push_addr    = stack_cnt_ff[AW-1:0];
      push_data    = {cur_row_ff, cur_col_ff};

      res             = '0;
      res.from_row    = cur_row_ff;
      res.from_col    = cur_col_ff;
      res.wall_dir    = rdmc_pkg::DIR_UP;

      if (req_fire) begin
         if (req_op == rdmc_pkg::OP_START) begin
            visited_in                   = '0;
            visited_in[{st_row, st_col}] = 1'b1;
            vcount_in    = VW'(1);
            push_en      = 1'b1;
            push_addr    = '0;
            push_data    = {st_row, st_col};
            stack_cnt_in = CNTW'(1);
            cur_row_in   = st_row;
            cur_col_in   = st_col;
            pref_in      = req_random_dir;
            finished_in  = 1'b0;
            res.from_row = st_row;
            res.from_col = st_col;
         end else if (finished_ff) begin
            res.done_res = 1'b1;
         end else if (found) begin
            visited_in[nb_idx[sel_dir]] = 1'b1;
            vcount_in  = VW'(vcount_ff + VW'(1));
            cur_row_in = nb_idx[sel_dir][EW-1:CW];
            cur_col_in = nb_idx[sel_dir][CW-1:0];
            pref_in    = req_random_dir;
            // full stack: cell is still entered, the push is dropped
            if (stack_cnt_ff < CNTW'(STACK_DEPTH)) begin
               push_en      = 1'b1;
               push_data    = nb_idx[sel_dir];
               stack_cnt_in = CNTW'(stack_cnt_ff + CNTW'(1));
            end
            finished_in  = (vcount_in >= side_sq);
            res.carved   = 1'b1;
            res.wall_dir = sel_dir;
            res.done_res = finished_in;
         end else if (stack_cnt_ff == '0) begin
            finished_in  = 1'b1;
            res.done_res = 1'b1;
         end else begin
            // dead end: pop and return to the entry below the old top, or finish if none is left
            stack_cnt_in    = cnt_dec;
            res.backtracked = 1'b1;
            if (cnt_dec == '0) begin
               finished_in = 1'b1;
            end else begin
               cur_row_in = below_top_ff[EW-1:CW];
               cur_col_in = below_top_ff[CW-1:0];
            end
            res.done_res = finished_in;
         end
      end
   end

   // Prefetch address: entry below the top for the next cycle's count.
   // Never equal to this cycle's push address.
   assign rd_addr = AW'(stack_cnt_in - CNTW'(2));

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[push_addr] <= push_data;
      end
      below_top_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_cfg_ff  <= rdmc_pkg::SIDE_RESET;
         visited_ff   <= '0;
         stack_cnt_ff <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         pref_ff      <= rdmc_pkg::DIR_UP;
         vcount_ff    <= '0;
         finished_ff  <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            side_cfg_ff <= csr_wr_data;
         end
         visited_ff   <= visited_in;
         stack_cnt_ff <= stack_cnt_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         pref_ff      <= pref_in;
         vcount_ff    <= vcount_in;
         finished_ff  <= finished_in;
      end
   end

   // ---------------------------------------------------------------
   // Response queue, two entries
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         res_q_ff[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff  <= '0;
      end else begin
         if (req_fire) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (rsp_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         q_cnt_ff <= 2'(q_cnt_ff + 2'(req_fire) - 2'(rsp_fire));
      end
   end

   assign rsp_valid       = (q_cnt_ff != '0);
   assign rsp_carved      = res_q_ff[rd_ptr_ff].carved;
   assign rsp_from_row    = res_q_ff[rd_ptr_ff].from_row;
   assign rsp_from_col    = res_q_ff[rd_ptr_ff].from_col;
   assign rsp_wall_dir    = res_q_ff[rd_ptr_ff].wall_dir;
   assign rsp_backtracked = res_q_ff[rd_ptr_ff].backtracked;
   assign rsp_done_res    = res_q_ff[rd_ptr_ff].done_res;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_carve_xor_pop : assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !(res.carved && res.backtracked))
      else $error("carve and pop in the same beat");

   a_carve_counts : assert property (@(posedge clock) disable iff (reset)
      (req_fire && res.carved) |=> (vcount_ff == VW'($past(vcount_ff) + VW'(1))))
      else $error("visited count did not advance on carve");

   a_carve_marks : assert property (@(posedge clock) disable iff (reset)
      (req_fire && res.carved) |=> visited_ff[{cur_row_ff, cur_col_ff}])
      else $error("walker moved onto an unmarked cell");

   a_finished_frozen : assert property (@(posedge clock) disable iff (reset)
      (finished_ff && !(req_fire && req_op == rdmc_pkg::OP_START))
         |=> ($stable(stack_cnt_ff) && $stable(visited_ff) && finished_ff))
      else $error("state changed while finished");

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      (q_cnt_ff == 2'd2) |-> !req_ready)
      else $error("request taken with full response queue");

endmodule

`default_nettype wire

// File: sim/random_dfs_maze_carver_checker.sv
`timescale 1ns / 1ps
// Result checker for random_dfs_maze_carver: watches the req, rsp and csr ports,
// predicts each result beat and compares it field by field. Depends on rdmc_pkg.
module random_dfs_maze_carver_checker #(
   parameter int TRAIL_DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic       req_op,
   input  wire logic [3:0] req_start_row,
   input  wire logic [3:0] req_start_col,
   input  wire logic [1:0] req_random_dir,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_carved,
   input  wire logic [3:0] rsp_from_row,
   input  wire logic [3:0] rsp_from_col,
   input  wire logic [1:0] rsp_wall_dir,
   input  wire logic       rsp_backtracked,
   input  wire logic       rsp_done_res,
   input  wire logic       csr_wr_en,
   input  wire logic [4:0] csr_wr_data,
   output int              outstanding,
   output int              failures
);

   // walker model
   logic                        visited [rdmc_pkg::MAX_SIDE][rdmc_pkg::MAX_SIDE];
   logic [rdmc_pkg::CELL_W-1:0] trail [TRAIL_DEPTH];
   int                          trail_depth;
   int                          walker_row;
   int                          walker_col;
   logic [1:0]                  heading;
   int                          cells_seen;
   logic                        maze_done;
   logic [rdmc_pkg::SIDE_W-1:0] side_setting;

   rdmc_pkg::result_type        pending_moves [$];

   function automatic void push_cell(int r, int c);
      if (trail_depth < TRAIL_DEPTH) begin
         trail[trail_depth] = {4'(r), 4'(c)};
         trail_depth++;
      end
   endfunction

   function automatic rdmc_pkg::result_type predict_move(logic op, logic [3:0] row_in,
                                                         logic [3:0] col_in,
                                                         logic [1:0] rnd);
      rdmc_pkg::result_type res;
      int         side;
      int         r;
      int         c;
      int         nr;
      int         nc;
      logic [1:0] d;
      bit         open;
      res = '0;
      side = (side_setting < rdmc_pkg::SIDE_MIN) ? int'(rdmc_pkg::SIDE_MIN) :
             (side_setting > rdmc_pkg::SIDE_MAX) ? int'(rdmc_pkg::SIDE_MAX) :
             int'(side_setting);
      res.from_row = 4'(walker_row);
      res.from_col = 4'(walker_col);
      if (op == rdmc_pkg::OP_START) begin
         r = (int'(row_in) > side - 1) ? side - 1 : int'(row_in);
         c = (int'(col_in) > side - 1) ? side - 1 : int'(col_in);
         foreach (visited[i, j]) visited[i][j] = 1'b0;
         trail_depth = 0;
         visited[r][c] = 1'b1;
         cells_seen = 1;
         push_cell(r, c);
         walker_row = r;
         walker_col = c;
         heading = rnd;
         maze_done = 1'b0;
         res.from_row = 4'(r);
         res.from_col = 4'(c);
      end else if (maze_done) begin
         res.done_res = 1'b1;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (!res.carved) begin
               d = heading + 2'(k);
               nr = walker_row;
               nc = walker_col;
               case (d)
                  rdmc_pkg::DIR_UP: begin
                     open = walker_row > 0;        nr = walker_row - 1;
                  end
                  rdmc_pkg::DIR_DOWN: begin
                     open = walker_row + 1 < side; nr = walker_row + 1;
                  end
                  rdmc_pkg::DIR_LEFT: begin
                     open = walker_col > 0;        nc = walker_col - 1;
                  end
                  default: begin
                     open = walker_col + 1 < side; nc = walker_col + 1;
                  end
               endcase
               if (open && nr < rdmc_pkg::MAX_SIDE && nc < rdmc_pkg::MAX_SIDE &&
                   !visited[nr][nc]) begin
                  visited[nr][nc] = 1'b1;
                  cells_seen = (cells_seen + 1) & 'h1FF;
                  push_cell(nr, nc);
                  walker_row = nr;
                  walker_col = nc;
                  heading = rnd;
                  res.carved = 1'b1;
                  res.wall_dir = d;
               end
            end
         end
         if (res.carved) begin
            if (cells_seen >= side * side) maze_done = 1'b1;
         end else if (trail_depth == 0) begin
            maze_done = 1'b1;
         end else begin
            // dead end: back up one cell
            trail_depth--;
            res.backtracked = 1'b1;
            if (trail_depth == 0) begin
               maze_done = 1'b1;
            end else begin
               walker_row = int'(trail[trail_depth-1][rdmc_pkg::CELL_W-1:rdmc_pkg::COORD_W]);
               walker_col = int'(trail[trail_depth-1][rdmc_pkg::COORD_W-1:0]);
            end
         end
         res.done_res = maze_done;
      end
      return res;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rdmc_pkg::result_type want;
      rdmc_pkg::result_type got;
      if (reset) begin
         foreach (visited[i, j]) visited[i][j] = 1'b0;
         trail_depth = 0;
         walker_row = 0;
         walker_col = 0;
         heading = rdmc_pkg::DIR_UP;
         cells_seen = 0;
         maze_done = 1'b1;
         side_setting = rdmc_pkg::SIDE_RESET;
         pending_moves.delete();
         failures = 0;
         outstanding <= 0;
      end else begin
         // result first: it can never belong to a request taken at this edge
         if (rsp_valid && rsp_ready) begin
            got = {rsp_carved, rsp_from_row, rsp_from_col, rsp_wall_dir,
                   rsp_backtracked, rsp_done_res};
            if (pending_moves.size() == 0) begin
               failures++;
               $display("%0t: unexpected result beat, expected none actual %h",
                        $realtime, got);
            end else begin
               want = pending_moves.pop_front();
               check_field("carved", int'(want.carved), int'(got.carved));
               check_field("from_row", int'(want.from_row), int'(got.from_row));
               check_field("from_col", int'(want.from_col), int'(got.from_col));
               check_field("wall_dir", int'(want.wall_dir), int'(got.wall_dir));
               check_field("backtracked", int'(want.backtracked),
                           int'(got.backtracked));
               check_field("done_res", int'(want.done_res), int'(got.done_res));
            end
         end
         if (req_valid && req_ready)
            pending_moves.push_back(predict_move(req_op, req_start_row, req_start_col,
                                                 req_random_dir));
         // a side write applies to beats taken after this edge
         if (csr_wr_en) side_setting = csr_wr_data;
         outstanding <= pending_moves.size();
      end
   end

endmodule

// File: sim/random_dfs_maze_carver_test.sv
`timescale 1ns / 1ps
// Top-level testbench for random_dfs_maze_carver: drives req/csr beats, random rsp stalls.
// Depends on rdmc_pkg, random_dfs_maze_carver and random_dfs_maze_carver_checker.
module random_dfs_maze_carver_test;

   // quiet cycles (no beat on any port) before the run is declared hung
   localparam int QUIET_LIMIT = 4000;
   // length of the long receiver hold-off that backs the block up
   localparam int HOLD_CYCLES = 80;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_op = rdmc_pkg::OP_START;
   logic [3:0] req_start_row = '0;
   logic [3:0] req_start_col = '0;
   logic [1:0] req_random_dir = rdmc_pkg::DIR_UP;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_carved;
   logic [3:0] rsp_from_row;
   logic [3:0] rsp_from_col;
   logic [1:0] rsp_wall_dir;
   logic       rsp_backtracked;
   logic       rsp_done_res;

   logic       csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = rdmc_pkg::SIDE_RESET;

   int         outstanding;
   int         failures;

   // idle rates in percent; the sender's is only touched by the stimulus process
   int         send_idle_pct = 0;
   int         take_idle_pct = 0;
   // bumped by the stimulus to ask the receiver for one long hold-off
   int         hold_ask = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   random_dfs_maze_carver DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_start_row  (req_start_row),
      .req_start_col  (req_start_col),
      .req_random_dir (req_random_dir),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_carved     (rsp_carved),
      .rsp_from_row   (rsp_from_row),
      .rsp_from_col   (rsp_from_col),
      .rsp_wall_dir   (rsp_wall_dir),
      .rsp_backtracked(rsp_backtracked),
      .rsp_done_res   (rsp_done_res),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   random_dfs_maze_carver_checker carve_watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_start_row  (req_start_row),
      .req_start_col  (req_start_col),
      .req_random_dir (req_random_dir),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_carved     (rsp_carved),
      .rsp_from_row   (rsp_from_row),
      .rsp_from_col   (rsp_from_col),
      .rsp_wall_dir   (rsp_wall_dir),
      .rsp_backtracked(rsp_backtracked),
      .rsp_done_res   (rsp_done_res),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .outstanding    (outstanding),
      .failures       (failures)
   );

   // Receiver: random stalls at the current rate. A new hold_ask value starts a
   // long hold-off, counted here, during which the sender keeps pushing beats.
   initial begin
      int seen_ask;
      int hold_left;
      seen_ask = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask != seen_ask) begin
            seen_ask = hold_ask;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   // Watchdog: any beat on req, rsp or csr resets the quiet count.
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $realtime, quiet);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Offer one req beat. Called just after a rising edge; returns just after
   // the edge that took it, with valid still high so back-to-back beats need
   // no extra assignment to valid.
   task automatic offer(input logic op, input logic [3:0] row, input logic [3:0] col,
                        input logic [1:0] dir);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_start_row  <= row;
      req_start_col  <= col;
      req_random_dir <= dir;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Grid side write, only ever done with the block idle.
   task automatic set_side(input logic [4:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic step(input logic [1:0] dir);
      offer(rdmc_pkg::OP_STEP, 4'($urandom_range(15)), 4'($urandom_range(15)), dir);
   endtask

   initial begin
      int seg_side [12];
      int eff;
      int left;
      int beats;

      seg_side = '{2, 3, 0, 5, 16, 4, 1, 31, 6, 17, 3, 2};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send_idle_pct = 30;
      take_idle_pct <= 69;
      // step with no maze running: reports done, walker at the origin
      step(rdmc_pkg::DIR_DOWN);
      // start outside a 15-wide grid: clamps to the far corner
      offer(rdmc_pkg::OP_START, 4'd15, 4'd15, rdmc_pkg::DIR_RIGHT);
      step(rdmc_pkg::DIR_LEFT);
      step(rdmc_pkg::DIR_DOWN);
      step(rdmc_pkg::DIR_UP);
      offer(rdmc_pkg::OP_START, 4'd0, 4'd0, rdmc_pkg::DIR_UP);
      step(rdmc_pkg::DIR_RIGHT);
      step(rdmc_pkg::DIR_LEFT);

      // smallest grid: three carves finish it, then two steps on a finished maze
      set_side(rdmc_pkg::SIDE_MIN);
      offer(rdmc_pkg::OP_START, 4'd9, 4'd10, rdmc_pkg::DIR_LEFT);
      repeat (5) step(2'($urandom_range(3)));

      // largest grid, then shrink it mid-walk (raw 0 clamps to 2)
      set_side(rdmc_pkg::SIDE_MAX);
      offer(rdmc_pkg::OP_START, 4'd15, 4'd0, rdmc_pkg::DIR_DOWN);
      step(rdmc_pkg::DIR_UP);
      step(rdmc_pkg::DIR_DOWN);
      step(rdmc_pkg::DIR_RIGHT);
      set_side(5'd0);
      repeat (3) step(2'($urandom_range(3)));

      // grow a 3-wide maze after some backing up, so it can pop to empty
      set_side(5'd3);
      offer(rdmc_pkg::OP_START, 4'd0, 4'd15, rdmc_pkg::DIR_UP);
      repeat (4) step(2'($urandom_range(3)));
      set_side(5'd16);
      repeat (4) step(2'($urandom_range(3)));

      // ---- random part ----
      // Mostly a start followed by roughly enough steps to finish the maze,
      // with stray starts mid-walk and extra steps past the end. Side writes
      // between segments land on mazes still in progress.
      left = 0;
      foreach (seg_side[s]) begin
         set_side(5'(seg_side[s]));
         eff = (seg_side[s] < 2) ? 2 : (seg_side[s] > 16) ? 16 : seg_side[s];
         if (s < 4) begin
            send_idle_pct = 30;
            take_idle_pct <= 69;
         end else if (s < 8) begin
            send_idle_pct = 69;
            take_idle_pct <= 30;
         end else begin
            send_idle_pct = 0;
            take_idle_pct <= 0;
         end
         // no idling on either side: a long hold-off fills the rsp queue
         if (s == 8) hold_ask <= hold_ask + 1;
         beats = $urandom_range(30, 40);
         repeat (beats) begin
            if (left <= 0 || $urandom_range(99) < 4) begin
               offer(rdmc_pkg::OP_START, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     2'($urandom_range(3)));
               left = $urandom_range(eff * eff, 2 * eff * eff + 3);
            end else begin
               step(2'($urandom_range(3)));
               left--;
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/rdmc_pkg.sv
sv/random_dfs_maze_carver.sv
sim/random_dfs_maze_carver_checker.sv
sim/random_dfs_maze_carver_test.sv
